// ===== hdl/rgbk_pkg.sv =====
// rgbk_pkg: shared types and constants for the rgb 3x3 kernel filter
// no dependencies; used by every module of the block
`default_nettype none

package rgbk_pkg;

    localparam int MaxWidth  = 1024;
    localparam int MaxHeight = 1024;
    localparam int COL_W     = $clog2(MaxWidth);
    localparam int ROW_W     = $clog2(MaxHeight);
    localparam int WDIM_W    = COL_W + 1;
    localparam int HDIM_W    = ROW_W + 1;
    localparam int SUM_W     = 14;
    localparam int BoxRecip  = 7282;
    localparam int PIX_W     = 24;

    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    typedef enum logic [1:0] {
        MODE_EDGE    = 2'd0,
        MODE_SHARPEN = 2'd1,
        MODE_BOX     = 2'd2,
        MODE_GAUSS   = 2'd3
    } mode_t;

    localparam logic [2:0] CFG_MODE   = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_LEFT   = 3'd3;
    localparam logic [2:0] CFG_TOP    = 3'd4;
    localparam logic [2:0] CFG_RIGHT  = 3'd5;
    localparam logic [2:0] CFG_BOTTOM = 3'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       frame_last;
    } out_item_t;

    typedef struct packed {
        mode_t              mode;
        logic [WDIM_W-1:0]  width;
        logic [HDIM_W-1:0]  height;
        logic [COL_W-1:0]   left;
        logic [ROW_W-1:0]   top;
        logic [WDIM_W-1:0]  right;
        logic [HDIM_W-1:0]  bottom;
    } cfg_t;

    typedef struct packed {
        logic              flush;
        logic              emit;
        logic              sel_upper;
        logic              filt;
        logic              last;
        mode_t             mode;
        logic [COL_W-1:0]  addr;
        logic [PIX_W-1:0]  pix;
    } op_t;

endpackage

`default_nettype wire

// ===== hdl/rgbk_front.sv =====
// rgbk_front: position and pending-count tracking, classifies each item
// depends on rgbk_pkg
`default_nettype none

module rgbk_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             accept,
    input  wire rgbk_pkg::in_item_t s_data,
    input  wire rgbk_pkg::cfg_t   cfg,
    output logic                  push,
    output rgbk_pkg::op_t         push_op
);
    import rgbk_pkg::*;

    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [WDIM_W-1:0] pend_reg, pend_next;

    logic [WDIM_W-1:0] w_eff;
    logic [HDIM_W-1:0] h_eff;
    logic [WDIM_W:0]   w_plus;
    logic              is_pix, pend_full, pend_any, emit;
    logic [WDIM_W-1:0] qc_x, ic_x;
    logic [HDIM_W-1:0] qr_x, ir_x;

    always_comb begin
        if (cfg.width == '0) begin
            w_eff = WDIM_W'(1);
        end else if (cfg.width > WDIM_W'(MaxWidth)) begin
            w_eff = WDIM_W'(MaxWidth);
        end else begin
            w_eff = cfg.width;
        end
        if (cfg.height == '0) begin
            h_eff = HDIM_W'(1);
        end else if (cfg.height > HDIM_W'(MaxHeight)) begin
            h_eff = HDIM_W'(MaxHeight);
        end else begin
            h_eff = cfg.height;
        end
    end

    assign w_plus    = {1'b0, w_eff} + (WDIM_W+1)'(1);
    assign is_pix    = (s_data.command == CMD_PIXEL);
    assign pend_full = ({1'b0, pend_reg} >= w_plus);
    assign pend_any  = (pend_reg != '0);
    assign emit      = is_pix ? pend_full : pend_any;
    assign qc_x      = WDIM_W'(out_col_reg);
    assign qr_x      = HDIM_W'(out_row_reg);
    assign ic_x      = WDIM_W'(in_col_reg);
    assign ir_x      = HDIM_W'(in_row_reg);
    assign push      = accept && (is_pix || pend_any);

    always_comb begin
        push_op.flush     = !is_pix;
        push_op.emit      = emit;
        push_op.sel_upper = (pend_reg > w_eff);
        push_op.filt      = is_pix
                            && (out_col_reg >= cfg.left) && (qc_x < cfg.right)
                            && (out_row_reg >= cfg.top) && (qr_x < cfg.bottom)
                            && (out_col_reg != '0) && (out_row_reg != '0)
                            && (qc_x + WDIM_W'(1) < w_eff) && (qr_x + HDIM_W'(1) < h_eff);
        push_op.last      = (qc_x + WDIM_W'(1) == w_eff) && (qr_x + HDIM_W'(1) == h_eff);
        push_op.mode      = cfg.mode;
        push_op.addr      = is_pix ? in_col_reg : out_col_reg;
        push_op.pix       = {s_data.in_red, s_data.in_green, s_data.in_blue};
    end

    always_comb begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (accept) begin
            if (emit) begin
                if (qc_x + WDIM_W'(1) >= w_eff) begin
                    out_col_next = '0;
                    out_row_next = (qr_x + HDIM_W'(1) >= h_eff) ? '0 : out_row_reg + ROW_W'(1);
                end else begin
                    out_col_next = out_col_reg + COL_W'(1);
                end
            end
            if (is_pix) begin
                pend_next = emit ? w_plus[WDIM_W-1:0] : pend_reg + WDIM_W'(1);
                if (ic_x + WDIM_W'(1) >= w_eff) begin
                    in_col_next = '0;
                    in_row_next = (ir_x + HDIM_W'(1) >= h_eff) ? '0 : in_row_reg + ROW_W'(1);
                end else begin
                    in_col_next = in_col_reg + COL_W'(1);
                end
            end else if (pend_any) begin
                pend_next = pend_reg - WDIM_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            pend_reg    <= '0;
        end else begin
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgbk_queue.sv =====
// rgbk_queue: four-entry operation queue between front and back
// depends on rgbk_pkg
`default_nettype none

module rgbk_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire rgbk_pkg::op_t push_op,
    input  wire logic          pop,
    output logic               full,
    output logic               head_valid,
    output rgbk_pkg::op_t      head_op
);
    import rgbk_pkg::*;

    localparam int QDepth = 4;
    localparam int QPTR_W = $clog2(QDepth);

    op_t               entry_reg [QDepth];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (QPTR_W+1)'(QDepth));
    assign head_valid = (count_reg != '0);
    assign head_op    = entry_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + (QPTR_W+1)'(1);
        end else if (pop && !push) begin
            count_next = count_reg - (QPTR_W+1)'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/rgbk_back.sv =====
// rgbk_back: line store memory, 3x3 window, kernel sums and result register
// depends on rgbk_pkg
`default_nettype none

module rgbk_back (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          head_valid,
    input  wire rgbk_pkg::op_t head_op,
    output logic               pop,
    output logic               m_valid,
    input  wire logic          m_ready,
    output rgbk_pkg::out_item_t m_data
);
    import rgbk_pkg::*;

    localparam int LINE_W = 2 * PIX_W;

    // line stores: upper half older row, lower half newer row
    logic [LINE_W-1:0] line_mem [MaxWidth];

    logic              adv;
    logic              a_valid_reg, b_valid_reg, c_valid_reg, m_valid_reg;
    op_t               a_op_reg, b_op_reg, c_op_reg;
    logic [LINE_W-1:0] rd_reg, byp_data_reg, rd_eff;
    logic              byp_reg;
    logic [PIX_W-1:0]  upper_rd, lower_rd, b_pix_reg, b_out_pix, c_pix_reg;
    logic [PIX_W-1:0]  win_reg [9];
    logic signed [SUM_W-1:0] c_sum_reg [3];
    logic signed [SUM_W-1:0] b_sum [3];
    out_item_t         m_data_reg, m_data_next;

    function automatic logic signed [SUM_W-1:0] kernel_sum(
        input logic [8:0][7:0] p,
        input mode_t           m
    );
        logic signed [SUM_W-1:0] nbr, corner, ctr, res;
        nbr    = $signed(SUM_W'(p[1]) + SUM_W'(p[3]) + SUM_W'(p[5]) + SUM_W'(p[7]));
        corner = $signed(SUM_W'(p[0]) + SUM_W'(p[2]) + SUM_W'(p[6]) + SUM_W'(p[8]));
        ctr    = $signed(SUM_W'(p[4]));
        unique case (m)
            MODE_EDGE:    res = (ctr <<< 3) - nbr - corner;
            MODE_SHARPEN: res = (ctr <<< 2) + ctr - nbr;
            MODE_BOX:     res = corner + nbr + ctr;
            MODE_GAUSS:   res = corner + (nbr <<< 1) + (ctr <<< 2);
            default:      res = '0;
        endcase
        return res;
    endfunction

    function automatic logic [7:0] chan_out(
        input logic signed [SUM_W-1:0] s,
        input mode_t                   m
    );
        logic [SUM_W-3:0]        x;
        logic [SUM_W+12:0]       prod;
        logic signed [SUM_W-1:0] v;
        logic [7:0]              res;
        x    = (SUM_W-2)'(s + SUM_W'(4));
        prod = (SUM_W+13)'(x) * (SUM_W+13)'(BoxRecip);
        unique case (m)
            MODE_BOX:   v = $signed(SUM_W'(prod >> 16));
            MODE_GAUSS: v = (s + SUM_W'(8)) >>> 4;
            default:    v = s;
        endcase
        if (v < 0) begin
            res = 8'd0;
        end else if (v > SUM_W'(255)) begin
            res = 8'd255;
        end else begin
            res = v[7:0];
        end
        return res;
    endfunction

    assign adv      = !m_valid_reg || m_ready;
    assign pop      = adv && head_valid;
    assign rd_eff   = byp_reg ? byp_data_reg : rd_reg;
    assign upper_rd = rd_eff[LINE_W-1:PIX_W];
    assign lower_rd = rd_eff[PIX_W-1:0];
    assign b_out_pix = b_op_reg.flush ? b_pix_reg : win_reg[4];

    always_comb begin
        logic [8:0][7:0] p;
        for (int ch = 0; ch < 3; ch++) begin
            for (int i = 0; i < 9; i++) begin
                p[i] = win_reg[i][8*(2-ch) +: 8];
            end
            b_sum[ch] = kernel_sum(p, b_op_reg.mode);
        end
    end

    always_comb begin
        m_data_next.out_red    = c_pix_reg[23:16];
        m_data_next.out_green  = c_pix_reg[15:8];
        m_data_next.out_blue   = c_pix_reg[7:0];
        m_data_next.frame_last = c_op_reg.last;
        if (c_op_reg.filt) begin
            m_data_next.out_red   = chan_out(c_sum_reg[0], c_op_reg.mode);
            m_data_next.out_green = chan_out(c_sum_reg[1], c_op_reg.mode);
            m_data_next.out_blue  = chan_out(c_sum_reg[2], c_op_reg.mode);
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_reg <= line_mem[head_op.addr];
            if (a_valid_reg && !a_op_reg.flush) begin
                line_mem[a_op_reg.addr] <= {lower_rd, a_op_reg.pix};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_op_reg     <= head_op;
            byp_reg      <= a_valid_reg && !a_op_reg.flush && (a_op_reg.addr == head_op.addr);
            byp_data_reg <= {lower_rd, a_op_reg.pix};
            b_op_reg     <= a_op_reg;
            b_pix_reg    <= a_op_reg.sel_upper ? upper_rd : lower_rd;
            c_op_reg     <= b_op_reg;
            c_pix_reg    <= b_out_pix;
            for (int ch = 0; ch < 3; ch++) begin
                c_sum_reg[ch] <= b_sum[ch];
            end
            if (c_valid_reg && c_op_reg.emit) begin
                m_data_reg <= m_data_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
        end else if (adv) begin
            a_valid_reg <= head_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            m_valid_reg <= c_valid_reg && c_op_reg.emit;
            if (a_valid_reg && !a_op_reg.flush) begin
                for (int r = 0; r < 3; r++) begin
                    win_reg[3*r]     <= win_reg[3*r + 1];
                    win_reg[3*r + 1] <= win_reg[3*r + 2];
                end
                win_reg[2] <= upper_rd;
                win_reg[5] <= lower_rd;
                win_reg[8] <= a_op_reg.pix;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== hdl/rgb_3x3_kernel_filter_unit.sv =====
// rgb_3x3_kernel_filter_unit: top level of the rgb 3x3 kernel filter
// depends on rgbk_pkg, rgbk_front, rgbk_queue, rgbk_back
//
// usage:
//   s_valid/s_ready/s_data carry items: a pixel (command 0) or a flush tick
//   (command 1), raster order. m_valid/m_ready/m_data return result items.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the seven registers; cfg_ready
//   is always high; the user makes writes while the block is idle, unenforced.
//   a pixel releases the pixel one row up and one column left once that
//   neighbourhood is complete; a flush tick drains one pending pixel.
//   throughput: one item per clock while the queue is not full. a result
//   passes the queue and line store read, the window, the kernel sum and the
//   divide and saturate steps on its way to m_data.
//   reset (aresetn low, synchronous) empties the queue and pipeline, clears
//   the window and position counters and restores the register defaults;
//   the line stores are not cleared.
//   while a result waits on m_ready low, it holds, the pipeline stops and the
//   four-entry queue keeps accepting until full, then s_ready drops.
`default_nettype none

module rgb_3x3_kernel_filter_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire rgbk_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output rgbk_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [2:0]          cfg_index,
    input  wire logic [10:0]         cfg_data
);
    import rgbk_pkg::*;

    cfg_t  cfg_reg, cfg_next;
    logic  accept, push, full, head_valid, pop;
    op_t   push_op, head_op;

    assign cfg_ready = 1'b1;
    assign s_ready   = !full;
    assign accept    = s_valid && s_ready;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_MODE:   cfg_next.mode   = mode_t'(cfg_data[1:0]);
                CFG_WIDTH:  cfg_next.width  = WDIM_W'(cfg_data);
                CFG_HEIGHT: cfg_next.height = HDIM_W'(cfg_data);
                CFG_LEFT:   cfg_next.left   = cfg_data[COL_W-1:0];
                CFG_TOP:    cfg_next.top    = cfg_data[ROW_W-1:0];
                CFG_RIGHT:  cfg_next.right  = WDIM_W'(cfg_data);
                CFG_BOTTOM: cfg_next.bottom = HDIM_W'(cfg_data);
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode   <= MODE_EDGE;
            cfg_reg.width  <= WDIM_W'(MaxWidth);
            cfg_reg.height <= HDIM_W'(MaxHeight);
            cfg_reg.left   <= '0;
            cfg_reg.top    <= '0;
            cfg_reg.right  <= WDIM_W'(MaxWidth);
            cfg_reg.bottom <= HDIM_W'(MaxHeight);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    rgbk_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .s_data  (s_data),
        .cfg     (cfg_reg),
        .push    (push),
        .push_op (push_op)
    );

    rgbk_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    rgbk_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_op    (head_op),
        .pop        (pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule

`default_nettype wire

// ===== hdl/rgbk_checker.sv =====
// rgbk_checker: port-level assertions for the rgb 3x3 kernel filter
// depends on rgbk_pkg; bound to rgb_3x3_kernel_filter_unit
`default_nettype none

module rgbk_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire rgbk_pkg::out_item_t m_data
);
    import rgbk_pkg::*;

    // no result item right after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // queue empty after reset so input is taken
    a_reset_ready: assert property (@(posedge aclk) !aresetn |=> s_ready)
        else $error("input not ready after reset");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result changed while stalled");

endmodule

bind rgb_3x3_kernel_filter_unit rgbk_checker u_rgbk_checker (.*);

`default_nettype wire

// ===== tb/sv/tb_rgb_3x3_kernel_filter_unit.sv =====
// tb_rgb_3x3_kernel_filter_unit: self-checking testbench for the rgb 3x3 kernel filter
// depends on rgbk_pkg and rgb_3x3_kernel_filter_unit; a directed table, then random frames
// checked against a built-in model of the window, line stores and kernels
`timescale 1ns / 1ps

module tb_rgb_3x3_kernel_filter_unit;
    import rgbk_pkg::*;

    typedef enum logic [1:0] {
        ROW_CFG  = 2'd0,
        ROW_NONE = 2'd1,
        ROW_RES  = 2'd2,
        ROW_PRED = 2'd3
    } row_kind_t;

    typedef struct {
        row_kind_t   kind;
        in_item_t    item;
        logic [2:0]  idx;
        logic [10:0] val;
        out_item_t   res;
    } dir_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [10:0] cfg_data;

    rgb_3x3_kernel_filter_unit u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // filter model state
    logic [23:0] up_line [MaxWidth];
    logic [23:0] lo_line [MaxWidth];
    logic [23:0] win [3][3];
    int col_pos, row_pos, held;
    int c_mode, c_w, c_h, c_left, c_top, c_right, c_bottom;

    out_item_t pixel_q [$];
    int fails, n_items, n_results, n_frames, n_flushed;
    int idle_pct, stall_pct;

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int sat_byte(int v);
        if (v < 0) return 0;
        if (v > 255) return 255;
        return v;
    endfunction

    function automatic int kernel_channel(int sh);
        int p [3][3];
        int s, nb;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                p[r][c] = (win[r][c] >> sh) & 8'hff;
        s = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                s += p[r][c];
        nb = p[0][1] + p[1][0] + p[1][2] + p[2][1];
        case (c_mode)
            MODE_EDGE:    return sat_byte(9 * p[1][1] - s);
            MODE_SHARPEN: return sat_byte(5 * p[1][1] - nb);
            MODE_BOX:     return sat_byte((s * 2 + 9) / 18);
            default: begin
                s = p[0][0] + p[0][2] + p[2][0] + p[2][2] + 2 * nb + 4 * p[1][1];
                return sat_byte((s + 8) / 16);
            end
        endcase
    endfunction

    function automatic void pos_back(int j, int w, int h, output int qr, output int qc);
        longint tot, idx, qi;
        tot = longint'(w) * h;
        idx = (longint'(row_pos) * w + col_pos) % tot;
        qi = (idx + tot * (j / tot + 1) - j) % tot;
        qr = int'(qi / w);
        qc = int'(qi % w);
    endfunction

    function automatic out_item_t make_res(logic [23:0] pix, int qr, int qc, int w, int h);
        out_item_t o;
        o.out_red    = pix[23:16];
        o.out_green  = pix[15:8];
        o.out_blue   = pix[7:0];
        o.frame_last = (qr + 1 == h && qc + 1 == w);
        return o;
    endfunction

    function automatic void filter_step(in_item_t it, output bit has, output out_item_t o);
        int w, h, qr, qc, cl;
        logic [23:0] pix, res;
        w = clamp_dim(c_w, MaxWidth);
        h = clamp_dim(c_h, MaxHeight);
        has = 1'b0;
        o = '0;
        if (it.command == CMD_PIXEL) begin
            pix = {it.in_red, it.in_green, it.in_blue};
            cl = col_pos % MaxWidth;
            for (int r = 0; r < 3; r++) begin
                win[r][0] = win[r][1];
                win[r][1] = win[r][2];
            end
            win[0][2] = up_line[cl];
            win[1][2] = lo_line[cl];
            win[2][2] = pix;
            up_line[cl] = lo_line[cl];
            lo_line[cl] = pix;
            if (held >= w + 1) begin
                res = win[1][1];
                pos_back(w + 1, w, h, qr, qc);
                if (qc >= c_left && qc < c_right && qr >= c_top && qr < c_bottom &&
                    qc > 0 && qr > 0 && qc + 1 < w && qr + 1 < h)
                    res = {8'(kernel_channel(16)), 8'(kernel_channel(8)),
                           8'(kernel_channel(0))};
                o = make_res(res, qr, qc, w, h);
                has = 1'b1;
                held = w + 1;
            end else begin
                held++;
            end
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        end else if (held != 0) begin
            pos_back(held, w, h, qr, qc);
            o = make_res(held <= w ? lo_line[qc] : up_line[qc], qr, qc, w, h);
            has = 1'b1;
            held--;
        end
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [10:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_MODE:   c_mode   = val[1:0];
            CFG_WIDTH:  c_w      = val;
            CFG_HEIGHT: c_h      = val;
            CFG_LEFT:   c_left   = val[9:0];
            CFG_TOP:    c_top    = val[9:0];
            CFG_RIGHT:  c_right  = val;
            default:    c_bottom = val;
        endcase
        @(negedge aclk);
    endtask

    // use_model: push the model's result; otherwise the caller supplies it
    task automatic send_item(in_item_t it, bit use_model, bit typed_has, out_item_t typed);
        bit has;
        out_item_t o;
        while ($urandom_range(99) < idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data  = it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        filter_step(it, has, o);
        if (use_model) begin
            if (has) pixel_q.push_back(o);
        end else if (typed_has) begin
            pixel_q.push_back(typed);
        end
        n_items++;
        if (it.command == CMD_FLUSH) n_flushed++;
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic in_item_t rand_pixel();
        in_item_t it;
        it.command = CMD_PIXEL;
        it.in_red   = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                               : 8'($urandom);
        it.in_green = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                               : 8'($urandom);
        it.in_blue  = ($urandom_range(7) == 0) ? ($urandom_range(1) ? 8'hff : 8'h00)
                                               : 8'($urandom);
        return it;
    endfunction

    always @(negedge aclk) begin
        if (aresetn) m_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pixel_q.size() == 0) begin
                $error("unexpected result item %h", m_data);
                fails++;
            end else begin
                e = pixel_q.pop_front();
                if (m_data.out_red !== e.out_red) begin
                    $error("out_red exp %h got %h", e.out_red, m_data.out_red);
                    fails++;
                end
                if (m_data.out_green !== e.out_green) begin
                    $error("out_green exp %h got %h", e.out_green, m_data.out_green);
                    fails++;
                end
                if (m_data.out_blue !== e.out_blue) begin
                    $error("out_blue exp %h got %h", e.out_blue, m_data.out_blue);
                    fails++;
                end
                if (m_data.frame_last !== e.frame_last) begin
                    $error("frame_last exp %b got %b", e.frame_last, m_data.frame_last);
                    fails++;
                end
            end
        end
    end

    initial begin
        #4000000;
        $display("FAIL rgb_3x3_kernel_filter_unit");
        $finish;
    end

    initial begin
        dir_row_t tbl [$];
        dir_row_t rw;
        in_item_t side, mid, fl;
        int w, h, npix, tot;

        s_valid = 1'b0; s_data = '0; m_ready = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        fails = 0; n_items = 0; n_results = 0; n_frames = 0; n_flushed = 0;
        idle_pct = 0; stall_pct = 0;
        for (int i = 0; i < MaxWidth; i++) begin
            up_line[i] = '0;
            lo_line[i] = '0;
        end
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                win[r][c] = '0;
        col_pos = 0; row_pos = 0; held = 0;
        c_mode = MODE_EDGE; c_w = 1024; c_h = 1024;
        c_left = 0; c_top = 0; c_right = 1024; c_bottom = 1024;

        aresetn = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: 3x3 edge frame with a bright-red centre, then a gaussian frame
        side = '{command: CMD_PIXEL, in_red: 8'h00, in_green: 8'hff, in_blue: 8'h00};
        mid  = '{command: CMD_PIXEL, in_red: 8'hff, in_green: 8'h00, in_blue: 8'h80};
        fl   = '{command: CMD_FLUSH, in_red: 8'h00, in_green: 8'h00, in_blue: 8'h00};
        tbl.push_back('{ROW_CFG, fl, CFG_WIDTH, 11'd3, '0});
        tbl.push_back('{ROW_CFG, fl, CFG_HEIGHT, 11'd3, '0});
        for (int i = 0; i < 4; i++) tbl.push_back('{ROW_NONE, (i == 3) ? side : side, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_RES, mid, 3'd0, 11'd0, {8'h00, 8'hff, 8'h00, 1'b0}});
        for (int i = 0; i < 3; i++)
            tbl.push_back('{ROW_RES, side, 3'd0, 11'd0, {8'h00, 8'hff, 8'h00, 1'b0}});
        tbl.push_back('{ROW_RES, side, 3'd0, 11'd0, {8'hff, 8'h00, 8'hff, 1'b0}});
        for (int i = 0; i < 4; i++)
            tbl.push_back('{ROW_RES, fl, 3'd0, 11'd0, {8'h00, 8'hff, 8'h00, i == 3}});
        tbl.push_back('{ROW_NONE, fl, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_CFG, fl, CFG_MODE, 11'(MODE_GAUSS), '0});
        for (int i = 0; i < 9; i++)
            tbl.push_back('{ROW_PRED, (i == 4) ? mid : side, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_PRED, fl, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_PRED, fl, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_PRED, fl, 3'd0, 11'd0, '0});
        tbl.push_back('{ROW_PRED, fl, 3'd0, 11'd0, '0});

        foreach (tbl[i]) begin
            rw = tbl[i];
            if (rw.kind == ROW_CFG) begin
                wait_idle();
                write_reg(rw.idx, rw.val);
                cfg_valid = 1'b0;
            end else begin
                send_item(rw.item, rw.kind == ROW_PRED, rw.kind == ROW_RES, rw.res);
            end
        end

        // random frames, each drained before the next setting
        while (n_items < 600) begin
            wait_idle();
            case (n_frames % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 80; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 80; end
                default: begin idle_pct = 25; stall_pct = 25; end
            endcase
            w = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
            h = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 7);
            write_reg(CFG_MODE, 11'($urandom_range(3)));
            write_reg(CFG_WIDTH, 11'(w));
            write_reg(CFG_HEIGHT, 11'(h));
            case ($urandom_range(4))
                0: begin
                    write_reg(CFG_LEFT, 11'd0); write_reg(CFG_TOP, 11'd0);
                    write_reg(CFG_RIGHT, 11'd1024); write_reg(CFG_BOTTOM, 11'd1024);
                end
                1: begin
                    write_reg(CFG_LEFT, 11'd1023); write_reg(CFG_TOP, 11'd1023);
                    write_reg(CFG_RIGHT, 11'd1); write_reg(CFG_BOTTOM, 11'd1);
                end
                default: begin
                    write_reg(CFG_LEFT, 11'($urandom_range(w)));
                    write_reg(CFG_TOP, 11'($urandom_range(h)));
                    write_reg(CFG_RIGHT, 11'($urandom_range(1, w + 1)));
                    write_reg(CFG_BOTTOM, 11'($urandom_range(1, h + 1)));
                end
            endcase
            cfg_valid = 1'b0;
            tot = w * h;
            npix = 0;
            while (npix < tot) begin
                if (held > 0 && $urandom_range(19) == 0) begin
                    send_item(fl, 1, 0, '0);
                end else begin
                    send_item(rand_pixel(), 1, 0, '0);
                    npix++;
                end
            end
            while (held > 0) send_item(fl, 1, 0, '0);
            if ($urandom_range(3) == 0) send_item(fl, 1, 0, '0);
            n_frames++;
        end

        s_valid = 1'b0;
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        $display("covered %0d items (%0d flush ticks) in %0d random frames, %0d results checked",
                 n_items, n_flushed, n_frames, n_results);
        $display("all four kernels, selections full, empty and partial, frame sizes 1 to 8");
        if (fails == 0) begin
            $display("PASS rgb_3x3_kernel_filter_unit");
        end else begin
            $display("FAIL rgb_3x3_kernel_filter_unit");
        end
        $finish;
    end

endmodule
